// ----- rtl/tast_pkg.sv -----
`timescale 1ns / 1ps

package tast_pkg;

   localparam int COORD_W = 20;
   localparam int REG_W   = 48;
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 5;

   localparam logic [REG_W-1:0] ALPHA_RESET = 48'd0;
   localparam logic [REG_W-1:0] DENOM_RESET = 48'd281475;
   localparam logic [REG_W-1:0] NUMER_RESET = 48'd18446744074;

   typedef enum logic [1:0] {
      REG_ALPHA = 2'd0,
      REG_DENOM = 2'd1,
      REG_NUMER = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
      logic signed [COORD_W-1:0] d_x;
      logic signed [COORD_W-1:0] d_y;
      logic signed [COORD_W-1:0] d_z;
   } req_data_type;

   typedef struct packed {
      logic passes;
      logic indeterminate;
   } rsp_data_type;

   typedef struct packed {
      logic [REG_W-1:0] alpha;
      logic [REG_W-1:0] denom;
      logic [REG_W-1:0] numer;
   } limits_type;

endpackage

// ----- rtl/tast_dly.sv -----
`timescale 1ns / 1ps

module tast_dly #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

// ----- rtl/tast_mul.sv -----
`timescale 1ns / 1ps

// signed multiplier, five register stages: magnitude, 32x32 partial products,
// row sums, total, sign
module tast_mul #(
   parameter int AW = 8,
   parameter int BW = 8
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);

   localparam int CW = 32;
   localparam int NA = (AW + CW - 1) / CW;
   localparam int NB = (BW + CW - 1) / CW;
   localparam int FW = (NA + NB) * CW;
   localparam int PW = AW + BW;

   logic [AW-1:0]      a_abs;
   logic [BW-1:0]      b_abs;
   logic [NA*CW-1:0]   a_mag_ff;
   logic [NB*CW-1:0]   b_mag_ff;
   logic [3:0]         neg_ff;
   logic [2*CW-1:0]    pp_ff [NA][NB];
   logic [FW-1:0]      row_in [NA];
   logic [FW-1:0]      row_ff [NA];
   logic [FW-1:0]      sum_in;
   logic [FW-1:0]      sum_ff;
   logic [PW-1:0]      mag;
   logic signed [PW-1:0] p_ff;

   assign a_abs = a[AW-1] ? (~a + 1'b1) : a;
   assign b_abs = b[BW-1] ? (~b + 1'b1) : b;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (FW'(pp_ff[i][j]) << (j * CW));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + (row_ff[i] << (i * CW));
      end
   end

   assign mag = sum_ff[PW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff <= (NA*CW)'(a_abs);
         b_mag_ff <= (NB*CW)'(b_abs);
         neg_ff   <= {neg_ff[2:0], a[AW-1] ^ b[BW-1]};
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_mag_ff[i*CW +: CW] * b_mag_ff[j*CW +: CW];
            end
            row_ff[i] <= row_in[i];
         end
         sum_ff <= sum_in;
         p_ff   <= neg_ff[3] ? -mag : mag;
      end
   end

   assign p = p_ff;

endmodule

// ----- rtl/tast_csr.sv -----
`timescale 1ns / 1ps

module tast_csr import tast_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output limits_type        limits
);

   limits_type  lim_ff;
   logic [1:0]  idx;

   assign idx    = paddr[4:3];
   assign pready = 1'b1;
   assign limits = lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff.alpha <= ALPHA_RESET;
         lim_ff.denom <= DENOM_RESET;
         lim_ff.numer <= NUMER_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            REG_ALPHA: lim_ff.alpha <= pwdata[REG_W-1:0];
            REG_DENOM: lim_ff.denom <= pwdata[REG_W-1:0];
            REG_NUMER: lim_ff.numer <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ALPHA: prdata = DATA_W'(lim_ff.alpha);
         REG_DENOM: prdata = DATA_W'(lim_ff.denom);
         REG_NUMER: prdata = DATA_W'(lim_ff.numer);
         default:   prdata = '0;
      endcase
   end

endmodule

// ----- rtl/tetra_alpha_shape_test_unit.sv -----
`timescale 1ns / 1ps
// throughput: one tetrahedron per cycle; the pipeline advances as one while the
// two-entry output queue has room, so a waiting result does not block intake
// reset: synchronous, clears valid bits and queue, limits return to defaults
// the latency is set by three chained wide multiplies of five stages each

module tetra_alpha_shape_test_unit import tast_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_data_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_data_type      rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int DW    = COORD_W + 1;
   localparam int PW    = 2 * DW;
   localparam int MW    = PW + 1;
   localparam int LW    = PW + 2;
   localparam int NTW   = MW + LW;
   localparam int NW    = NTW + 2;
   localparam int VTW   = MW + DW;
   localparam int VW    = VTW + 2;
   localparam int NUMW  = 2 * NW + 2;
   localparam int DENW  = 2 * VW + 2;
   localparam int AW    = REG_W + 1;
   localparam int PRW   = AW + DENW;
   localparam int CMPW  = (PRW > NUMW) ? PRW : NUMW;
   localparam int LAT   = 21;

   // minor axes per numerator (x pair y/z, y pair x/z, z pair x/y) and row pairs
   localparam int AXU  [3] = '{1, 0, 0};
   localparam int AXV  [3] = '{2, 2, 1};
   localparam int ROWA [3] = '{0, 0, 1};
   localparam int ROWB [3] = '{1, 2, 2};

   limits_type  limits;
   logic        en;
   logic [LAT-1:0] v_ff;

   logic signed [DW-1:0]  d_ff  [9];
   logic signed [PW-1:0]  sq_ff [9];
   logic signed [PW-1:0]  pa_ff [3][3];
   logic signed [PW-1:0]  pb_ff [3][3];
   logic signed [LW-1:0]  sl_ff [3];
   logic signed [MW-1:0]  mn_ff [3][3];
   logic [3*DW-1:0]       zd;
   logic signed [DW-1:0]  zv    [3];
   logic signed [NTW-1:0] nt    [3][3];
   logic signed [VTW-1:0] vt    [3];
   logic signed [NW-1:0]  n_ff  [3];
   logic signed [VW-1:0]  vol_ff;
   logic signed [2*NW-1:0] nsq  [3];
   logic signed [2*VW-1:0] vsq;
   logic [NUMW-1:0]       numer_ff;
   logic [DENW-1:0]       denom_ff;
   logic                  sliver_ff;
   logic                  sliver_d;
   logic [NUMW-1:0]       numer_d;
   logic signed [PRW-1:0] prod;
   rsp_data_type          res_ff;

   rsp_data_type          q_mem_ff [2];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;
   logic                  push;
   logic                  pop;

   tast_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   assign en        = (count_ff != 2'd2);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_valid};
      end
   end

   // edge vectors from the first vertex, rows q r s
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= DW'(req_data.b_x) - DW'(req_data.a_x);
         d_ff[1] <= DW'(req_data.b_y) - DW'(req_data.a_y);
         d_ff[2] <= DW'(req_data.b_z) - DW'(req_data.a_z);
         d_ff[3] <= DW'(req_data.c_x) - DW'(req_data.a_x);
         d_ff[4] <= DW'(req_data.c_y) - DW'(req_data.a_y);
         d_ff[5] <= DW'(req_data.c_z) - DW'(req_data.a_z);
         d_ff[6] <= DW'(req_data.d_x) - DW'(req_data.a_x);
         d_ff[7] <= DW'(req_data.d_y) - DW'(req_data.a_y);
         d_ff[8] <= DW'(req_data.d_z) - DW'(req_data.a_z);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            sq_ff[k] <= d_ff[k] * d_ff[k];
         end
         for (int g = 0; g < 3; g++) begin
            for (int m = 0; m < 3; m++) begin
               pa_ff[g][m] <= d_ff[ROWA[m]*3 + AXU[g]] * d_ff[ROWB[m]*3 + AXV[g]];
               pb_ff[g][m] <= d_ff[ROWB[m]*3 + AXU[g]] * d_ff[ROWA[m]*3 + AXV[g]];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            sl_ff[r] <= LW'(sq_ff[3*r]) + LW'(sq_ff[3*r+1]) + LW'(sq_ff[3*r+2]);
         end
         for (int g = 0; g < 3; g++) begin
            for (int m = 0; m < 3; m++) begin
               mn_ff[g][m] <= MW'(pa_ff[g][m]) - MW'(pb_ff[g][m]);
            end
         end
      end
   end

   // z components wait two stages to meet the volume minors
   tast_dly #(.WIDTH(3*DW), .DEPTH(2)) u_zdly (
      .clock (clock),
      .en    (en),
      .d     ({d_ff[8], d_ff[5], d_ff[2]}),
      .q     (zd)
   );

   for (genvar k = 0; k < 3; k++) begin : g_zv
      assign zv[k] = signed'(zd[k*DW +: DW]);
   end

   // cofactor expansion along the last column: m01*a22 - m02*a12 + m12*a02
   for (genvar g = 0; g < 3; g++) begin : g_num
      for (genvar m = 0; m < 3; m++) begin : g_term
         tast_mul #(.AW(MW), .BW(LW)) u_nmul (
            .clock (clock),
            .en    (en),
            .a     (mn_ff[g][m]),
            .b     (sl_ff[2-m]),
            .p     (nt[g][m])
         );
      end
   end

   for (genvar m = 0; m < 3; m++) begin : g_vol
      tast_mul #(.AW(MW), .BW(DW)) u_vmul (
         .clock (clock),
         .en    (en),
         .a     (mn_ff[2][m]),
         .b     (zv[2-m]),
         .p     (vt[m])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < 3; g++) begin
            n_ff[g] <= NW'(nt[g][0]) - NW'(nt[g][1]) + NW'(nt[g][2]);
         end
         vol_ff <= VW'(vt[0]) - VW'(vt[1]) + VW'(vt[2]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_nsq
      tast_mul #(.AW(NW), .BW(NW)) u_nsq (
         .clock (clock),
         .en    (en),
         .a     (n_ff[g]),
         .b     (n_ff[g]),
         .p     (nsq[g])
      );
   end

   tast_mul #(.AW(VW), .BW(VW)) u_vsq (
      .clock (clock),
      .en    (en),
      .a     (vol_ff),
      .b     (vol_ff),
      .p     (vsq)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         numer_ff <= NUMW'(nsq[0]) + NUMW'(nsq[1]) + NUMW'(nsq[2]);
         denom_ff <= DENW'(vsq) << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sliver_ff <= (denom_ff < DENW'(limits.denom)) &&
                      (numer_ff < NUMW'(limits.numer));
      end
   end

   // alpha * denominator, compared with the numerator to avoid a divide
   tast_mul #(.AW(AW), .BW(DENW)) u_amul (
      .clock (clock),
      .en    (en),
      .a     (signed'({1'b0, limits.alpha})),
      .b     (signed'(denom_ff)),
      .p     (prod)
   );

   tast_dly #(.WIDTH(1), .DEPTH(4)) u_sdly (
      .clock (clock),
      .en    (en),
      .d     (sliver_ff),
      .q     (sliver_d)
   );

   tast_dly #(.WIDTH(NUMW), .DEPTH(5)) u_ndly (
      .clock (clock),
      .en    (en),
      .d     (numer_ff),
      .q     (numer_d)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.indeterminate <= sliver_d;
         res_ff.passes        <= !sliver_d &&
                                 (CMPW'(numer_d) < CMPW'($unsigned(prod)));
      end
   end

   // two-entry output queue
   assign push      = en && v_ff[LAT-1];
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= res_ff;
      end
   end

endmodule

// ----- rtl/tast_checker.sv -----
`timescale 1ns / 1ps

module tast_checker import tast_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input req_data_type      req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_data_type      rsp_data,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [ADDR_W-1:0] paddr,
   input logic [DATA_W-1:0] pwdata,
   input logic [DATA_W-1:0] prdata,
   input logic              pready
);

   // queue empties on reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a sliver beat never passes
   a_sliver_no_pass : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.passes && rsp_data.indeterminate))
      else $error("sliver beat flagged as passing");

   // a written alpha limit reads back at once
   a_alpha_readback : assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[4:3] == REG_ALPHA)
      ##1 (psel && !pwrite && paddr[4:3] == REG_ALPHA)
      |-> prdata == DATA_W'($past(pwdata[REG_W-1:0])))
      else $error("alpha limit readback mismatch");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled req beat changed");

endmodule

bind tetra_alpha_shape_test_unit tast_checker u_checker (.*);

// ----- sim/tb_tetra_alpha_shape_test_unit.sv -----
`timescale 1ns / 1ps

module tb_tetra_alpha_shape_test_unit;
   import tast_pkg::*;

   typedef logic signed [255:0] big_t;
   typedef logic signed [COORD_W-1:0] crd_t;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 40;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_data_type      req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_data_type      rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   tetra_alpha_shape_test_unit dut (.*);

   // register mirror
   logic [REG_W-1:0] lim_alpha, lim_denom, lim_numer;

   req_data_type pending_cells[$];
   rsp_data_type verdicts_due[$];
   int           mismatches;
   int           cycles;
   bit           idle_on;
   int           send_gap;
   int           stall_left;
   bit           req_took;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic big_t ext(input crd_t v);
      big_t r;
      r = v;
      return r;
   endfunction

   function automatic big_t det3(input big_t a00, a01, a02, a10, a11, a12,
                                 a20, a21, a22);
      big_t m02, m01, m12;
      m02 = a00 * a21 - a20 * a01;
      m01 = a00 * a11 - a10 * a01;
      m12 = a10 * a21 - a20 * a11;
      return m01 * a22 - m02 * a12 + m12 * a02;
   endfunction

   function automatic rsp_data_type circumradius_verdict(input req_data_type c);
      big_t qx, qy, qz, rx, ry, rz, sx, sy, sz, q2, r2, s2;
      big_t nx, ny, nz, vol, numer, denom;
      rsp_data_type o;
      bit sliver;
      qx = ext(c.b_x) - ext(c.a_x);
      qy = ext(c.b_y) - ext(c.a_y);
      qz = ext(c.b_z) - ext(c.a_z);
      rx = ext(c.c_x) - ext(c.a_x);
      ry = ext(c.c_y) - ext(c.a_y);
      rz = ext(c.c_z) - ext(c.a_z);
      sx = ext(c.d_x) - ext(c.a_x);
      sy = ext(c.d_y) - ext(c.a_y);
      sz = ext(c.d_z) - ext(c.a_z);
      q2 = qx * qx + qy * qy + qz * qz;
      r2 = rx * rx + ry * ry + rz * rz;
      s2 = sx * sx + sy * sy + sz * sz;
      nx = det3(qy, qz, q2, ry, rz, r2, sy, sz, s2);
      ny = det3(qx, qz, q2, rx, rz, r2, sx, sz, s2);
      nz = det3(qx, qy, q2, rx, ry, r2, sx, sy, s2);
      vol = det3(qx, qy, qz, rx, ry, rz, sx, sy, sz);
      numer = nx * nx + ny * ny + nz * nz;
      denom = 4 * vol * vol;
      sliver = (denom < big_t'({208'd0, lim_denom})) &&
               (numer < big_t'({208'd0, lim_numer}));
      o.indeterminate = sliver;
      o.passes = !sliver && (numer < big_t'({208'd0, lim_alpha}) * denom);
      return o;
   endfunction

   task automatic report(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // driver: feeds beats at the falling edge
   always @(negedge clock) begin
      bit busy;
      if (!reset) begin
         busy = req_valid && !req_took;
         req_took = 1'b0;
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_cells.size() > 0) begin
               req_data  <= pending_cells.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_on ? $urandom_range(0, 12) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0) stall_left--;
         rsp_stall <= (stall_left > 0);
      end
   end

   // monitor: samples at the rising edge
   always @(posedge clock) begin
      rsp_data_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            verdicts_due = {verdicts_due, circumradius_verdict(req_data)};
            req_took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            stall_left = idle_on ? $urandom_range(0, 12) : 0;
            if (verdicts_due.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.passes !== want.passes)
                  report($sformatf("passes %b, expected %b", rsp_data.passes,
                                   want.passes));
               if (rsp_data.indeterminate !== want.indeterminate)
                  report($sformatf("indeterminate %b, expected %b",
                                   rsp_data.indeterminate, want.indeterminate));
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_cells.size() > 0 || req_valid || verdicts_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_limit(input int idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx * 8);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ALPHA: lim_alpha = value[REG_W-1:0];
         REG_DENOM: lim_denom = value[REG_W-1:0];
         REG_NUMER: lim_numer = value[REG_W-1:0];
         default: ;
      endcase
   endtask

   function automatic crd_t rand_crd(input int bits);
      logic signed [31:0] v;
      v = $urandom;
      return crd_t'((v <<< (32 - bits)) >>> (32 - bits));
   endfunction

   function automatic req_data_type make_cell(input crd_t ax, ay, az, bx, by, bz,
                                             cx, cy, cz, dx, dy, dz);
      req_data_type c;
      c = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
      return c;
   endfunction

   function automatic req_data_type random_cell();
      req_data_type c;
      logic [255:0] raw;
      int k, kind;
      crd_t ax, ay, az;
      kind = $urandom_range(0, 9);
      k = $urandom_range(1, 20);
      ax = rand_crd(20);
      ay = rand_crd(20);
      az = rand_crd(20);
      if (kind < 2) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
         c = raw[$bits(req_data_type)-1:0];
      end else if (kind < 8) begin
         // a cluster of points around the first vertex
         c = make_cell(ax, ay, az,
                       ax + rand_crd(k), ay + rand_crd(k), az + rand_crd(k),
                       ax + rand_crd(k), ay + rand_crd(k), az + rand_crd(k),
                       ax + rand_crd(k), ay + rand_crd(k), az + rand_crd(k));
      end else if (kind == 8) begin
         // fourth vertex in the plane of the first three
         c = make_cell(ax, ay, az,
                       ax + rand_crd(k), ay + rand_crd(k), az, ax + rand_crd(k),
                       ay + rand_crd(k), az, ax + rand_crd(k), ay + rand_crd(k), az);
      end else begin
         c = make_cell(ax, ay, az, ax, ay, az, ax + rand_crd(k), ay, az,
                       ax, ay + rand_crd(k), az + rand_crd(k));
      end
      return c;
   endfunction

   task automatic add_cell(input req_data_type c);
      pending_cells = {pending_cells, c};
   endtask

   task automatic directed_cells();
      crd_t mx, mn, u;
      mx = 20'sh7ffff;
      mn = 20'sh80000;
      u  = 20'sd256;
      add_cell(make_cell(0, 0, 0, u, 0, 0, 0, u, 0, 0, 0, u));
      add_cell(make_cell(mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx));
      add_cell(make_cell(mx, mx, mx, mn, mx, mx, mx, mn, mx, mx, mx, mn));
      add_cell(make_cell(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
      add_cell(make_cell(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
      add_cell(make_cell(0, 0, 0, u, 0, 0, 0, u, 0, u, u, 0));
      add_cell(make_cell(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
      add_cell(make_cell(mn, 0, mx, mx, mn, 0, 0, mx, mn, mn, mn, mn));
      add_cell(make_cell(0, 0, 0, 1, 0, 0, 2, 0, 0, 3, 0, 0));
      add_cell(make_cell(5, -7, 3, 900, 40, -20, -300, 800, 10, 60, -90, 1000));
   endtask

   task automatic random_cells(input int n);
      repeat (n) add_cell(random_cell());
   endtask

   initial begin
      logic [DATA_W-1:0] rv;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      mismatches = 0;
      cycles     = 0;
      idle_on    = 1'b0;
      send_gap   = 0;
      stall_left = 0;
      req_took   = 1'b0;
      lim_alpha  = ALPHA_RESET;
      lim_denom  = DENOM_RESET;
      lim_numer  = NUMER_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset, no idling
      directed_cells();
      random_cells(150);
      wait_idle();

      // sliver test off: a flat cell is not a sliver, so it cannot pass
      idle_on = 1'b1;
      write_limit(REG_NUMER, 64'd0);
      write_limit(REG_DENOM, 64'd0);
      write_limit(REG_ALPHA, 64'd1 << 40);
      directed_cells();
      random_cells(200);
      wait_idle();

      // top bits beyond the register are dropped, and a write past the end is ignored
      write_limit(REG_ALPHA, 64'hffff_ffff_ffff_ffff);
      write_limit(REG_DENOM, 64'hffff_ffff_ffff_ffff);
      write_limit(REG_NUMER, 64'hffff_ffff_ffff_ffff);
      write_limit(3, 64'd0);
      directed_cells();
      random_cells(150);
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         idle_on = ph[0];
         rv = {$urandom, $urandom};
         write_limit(REG_ALPHA, (rv >> $urandom_range(16, 63)) + 1);
         rv = {$urandom, $urandom};
         write_limit(REG_DENOM, rv >> $urandom_range(16, 63));
         rv = {$urandom, $urandom};
         write_limit(REG_NUMER, rv >> $urandom_range(16, 63));
         random_cells(100);
         if (ph == 2) begin
            // hold off the second batch until everything is back
            while (pending_cells.size() > 0 || req_valid || verdicts_due.size() > 0)
               @(posedge clock);
         end
         random_cells(100);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tast_pkg.sv
rtl/tast_dly.sv
rtl/tast_mul.sv
rtl/tast_csr.sv
rtl/tetra_alpha_shape_test_unit.sv
rtl/tast_checker.sv
sim/tb_tetra_alpha_shape_test_unit.sv
